[src/dssq_pkg.sv]
package dssq_pkg;

  // field widths
  localparam int ActionW = 3;
  localparam int StatusW = 16;
  localparam int CtrlW   = 8;
  localparam int StateW  = 3;
  localparam int NumStates = 8;

  typedef logic [ActionW-1:0] action_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CtrlW-1:0]   ctrl_t;
  typedef logic [StateW-1:0]  state_t;
  typedef logic [1:0]         goal_t;

  // request codes
  localparam action_t ACT_NONE    = 3'd0;
  localparam action_t ACT_ENABLE  = 3'd1;
  localparam action_t ACT_DISABLE = 3'd2;
  localparam action_t ACT_QSTOP   = 3'd3;
  localparam action_t ACT_FRESET  = 3'd4;

  // decoded drive states
  localparam state_t ST_NOTREADY = 3'd0;
  localparam state_t ST_SOD      = 3'd1;
  localparam state_t ST_READY    = 3'd2;
  localparam state_t ST_ON       = 3'd3;
  localparam state_t ST_ENABLED  = 3'd4;
  localparam state_t ST_QSTOP    = 3'd5;
  localparam state_t ST_REACTION = 3'd6;
  localparam state_t ST_FAULT    = 3'd7;

  // target codes
  localparam goal_t GOAL_NONE    = 2'd0;
  localparam goal_t GOAL_ENABLE  = 2'd1;
  localparam goal_t GOAL_DISABLE = 2'd2;
  localparam goal_t GOAL_QSTOP   = 2'd3;

  // control word commands
  localparam ctrl_t CW_NONE     = 8'h00;
  localparam ctrl_t CW_QSTOP    = 8'h02;
  localparam ctrl_t CW_SHUTDOWN = 8'h06;
  localparam ctrl_t CW_SWITCHON = 8'h07;
  localparam ctrl_t CW_ENABLEOP = 8'h0F;
  localparam ctrl_t CW_FRESET   = 8'h80;

  // status word bits
  localparam status_t SW_READY = 16'h0001;
  localparam status_t SW_ON    = 16'h0002;
  localparam status_t SW_OPEN  = 16'h0004;
  localparam status_t SW_FAULT = 16'h0008;
  localparam status_t SW_QSTOP = 16'h0020;
  localparam status_t SW_SOD   = 16'h0040;
  localparam status_t MASK_NOQ = SW_READY | SW_ON | SW_OPEN | SW_FAULT | SW_SOD;
  localparam status_t MASK_Q   = MASK_NOQ | SW_QSTOP;

  // state match table, indexed by state code
  localparam status_t MATCH_MASK [NumStates] = '{
    MASK_NOQ, MASK_NOQ, MASK_Q, MASK_Q, MASK_Q, MASK_Q, MASK_NOQ, MASK_NOQ
  };
  localparam status_t MATCH_VALUE [NumStates] = '{
    16'h0000,
    SW_SOD,
    SW_READY | SW_QSTOP,
    SW_READY | SW_ON | SW_QSTOP,
    SW_READY | SW_ON | SW_OPEN | SW_QSTOP,
    SW_READY | SW_ON | SW_OPEN,
    SW_READY | SW_ON | SW_OPEN | SW_FAULT,
    SW_FAULT
  };

  // one item handed to the sequencer core
  typedef struct packed {
    logic    valid;
    action_t action;
    state_t  state;
  } step_t;

endpackage

[src/dssq_if.sv]
interface dssq_in_if;
  logic               valid;
  logic               ready;
  dssq_pkg::action_t  action;
  dssq_pkg::status_t  status_word;

  modport source (output valid, output action, output status_word, input ready);
  modport sink   (input valid, input action, input status_word, output ready);
endinterface

interface dssq_out_if;
  logic              valid;
  logic              ready;
  dssq_pkg::ctrl_t   control_word;
  dssq_pkg::state_t  drive_state;

  modport source (output valid, output control_word, output drive_state, input ready);
  modport sink   (input valid, input control_word, input drive_state, output ready);
endinterface

[src/dssq_decode.sv]
module dssq_decode (
  input  dssq_pkg::status_t status_word,
  output dssq_pkg::state_t  drive_state
);

  // priority match, lowest state code wins
  always_comb begin
    drive_state = dssq_pkg::ST_NOTREADY;
    for (int i = dssq_pkg::NumStates - 1; i >= 0; i--) begin
      if ((status_word & dssq_pkg::MATCH_MASK[i]) == dssq_pkg::MATCH_VALUE[i]) begin
        drive_state = dssq_pkg::state_t'(i);
      end
    end
  end

endmodule

[src/dssq_cmd.sv]
module dssq_cmd (
  input  logic             clk,
  input  logic             rst_n,
  input  dssq_pkg::step_t  step,
  output dssq_pkg::ctrl_t  control_word
);

  dssq_pkg::goal_t goal_r, goal_nxt;
  logic            pend_r, pend_nxt;
  logic            sent_r, sent_nxt;
  logic            pend_a, sent_a;

  // apply the request, then the state, then pick the command
  always_comb begin
    goal_nxt = goal_r;
    pend_a   = pend_r;
    sent_a   = sent_r;
    case (step.action)
      dssq_pkg::ACT_ENABLE:  goal_nxt = dssq_pkg::GOAL_ENABLE;
      dssq_pkg::ACT_DISABLE: goal_nxt = dssq_pkg::GOAL_DISABLE;
      dssq_pkg::ACT_QSTOP:   goal_nxt = dssq_pkg::GOAL_QSTOP;
      dssq_pkg::ACT_FRESET: begin
        pend_a = 1'b1;
        sent_a = 1'b0;
      end
      default: ;
    endcase

    // pulse flags only survive while in fault
    if (step.state != dssq_pkg::ST_FAULT) begin
      pend_a = 1'b0;
      sent_a = 1'b0;
    end
    pend_nxt     = pend_a;
    sent_nxt     = sent_a;
    control_word = dssq_pkg::CW_NONE;

    if (step.state == dssq_pkg::ST_FAULT || step.state == dssq_pkg::ST_REACTION) begin
      if (pend_a && !sent_a) begin
        sent_nxt     = 1'b1;
        control_word = dssq_pkg::CW_FRESET;
      end
    end else begin
      case (goal_nxt)
        dssq_pkg::GOAL_QSTOP: begin
          if (step.state == dssq_pkg::ST_ENABLED || step.state == dssq_pkg::ST_ON ||
              step.state == dssq_pkg::ST_READY || step.state == dssq_pkg::ST_QSTOP) begin
            control_word = dssq_pkg::CW_QSTOP;
          end
        end
        dssq_pkg::GOAL_ENABLE: begin
          if (step.state == dssq_pkg::ST_SOD) begin
            control_word = dssq_pkg::CW_SHUTDOWN;
          end else if (step.state == dssq_pkg::ST_READY) begin
            control_word = dssq_pkg::CW_SWITCHON;
          end else if (step.state == dssq_pkg::ST_ON || step.state == dssq_pkg::ST_ENABLED) begin
            control_word = dssq_pkg::CW_ENABLEOP;
          end
        end
        default: control_word = dssq_pkg::CW_NONE;
      endcase
    end
  end

  // target and pulse flags advance once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= dssq_pkg::GOAL_NONE;
      pend_r <= 1'b0;
      sent_r <= 1'b0;
    end else if (step.valid) begin
      goal_r <= goal_nxt;
      pend_r <= pend_nxt;
      sent_r <= sent_nxt;
    end
  end

  // leaving fault drops both flags
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && step.state != dssq_pkg::ST_FAULT |=> !pend_r && !sent_r)
    else $error("pulse flags kept outside fault");

  // a reset pulse marks itself sent
  a_pulse_sent: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && control_word == dssq_pkg::CW_FRESET |=> sent_r && pend_r)
    else $error("reset pulse not recorded");

  // no second pulse without a fresh request
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r && step.action != dssq_pkg::ACT_FRESET |-> control_word != dssq_pkg::CW_FRESET)
    else $error("repeated reset pulse");

endmodule

[src/drive_state_controlword_sequencer_unit.sv]
// Drive state decoder and control word sequencer.
// in_ch carries one transaction per process-data cycle: a request code
// (none, enable, disable, quick stop, fault reset) and the status word
// read back from the drive. out_ch returns one transaction for each
// input: the control word to send and the decoded drive state.
// Both channels use a valid/ready handshake; a transaction moves on an
// edge where both are high.
// out_ch.valid rises once the result register holds the transaction: the
// input register loads on the accepting edge, then decode and command
// selection fill the result register when the pipeline advances.
// Throughput is one transaction per clock; both stages advance together
// whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous) clears the target to none, drops the
// pending/sent fault-reset flags and empties both stages; in_ch.ready
// is low during reset.
// When the receiver holds out_ch.ready low, the result stays put, the
// input register holds one more transaction, and then in_ch.ready drops.
module drive_state_controlword_sequencer_unit (
  input logic              clk,
  input logic              rst_n,
  dssq_in_if.sink          in_ch,
  dssq_out_if.source       out_ch
);

  logic               s1_valid_r;
  dssq_pkg::action_t  s1_action_r;
  dssq_pkg::status_t  s1_status_r;
  logic               out_valid_r;
  dssq_pkg::ctrl_t    out_cw_r;
  dssq_pkg::state_t   out_state_r;

  logic               advance;
  dssq_pkg::state_t   dec_state;
  dssq_pkg::ctrl_t    cmd_cw;
  dssq_pkg::step_t    step;

  // pipeline moves when the result register is free
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && (!s1_valid_r || advance);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_action_r <= in_ch.action;
      s1_status_r <= in_ch.status_word;
    end
  end

  // status decode
  dssq_decode u_decode (
    .status_word (s1_status_r),
    .drive_state (dec_state)
  );

  assign step.valid  = s1_valid_r && advance;
  assign step.action = s1_action_r;
  assign step.state  = dec_state;

  // command sequencer
  dssq_cmd u_cmd (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .control_word (cmd_cw)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      out_cw_r    <= cmd_cw;
      out_state_r <= dec_state;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.control_word = out_cw_r;
  assign out_ch.drive_state  = out_state_r;

  // an accepted transaction lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_valid_r)
    else $error("accepted transaction lost");

  // a stalled input register keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_status_r) && $stable(s1_action_r))
    else $error("input register changed under stall");

  // fault reaction never gets a reset pulse
  a_no_pulse_reaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_state_r == dssq_pkg::ST_REACTION |-> out_cw_r == dssq_pkg::CW_NONE)
    else $error("command issued during fault reaction");

endmodule

[test/drive_state_controlword_sequencer_unit_tb.sv]
module drive_state_controlword_sequencer_unit_tb;
  import dssq_pkg::*;

  // undefined request codes, ignored by the block
  localparam action_t ACT_RSVD5 = 3'd5;
  localparam action_t ACT_RSVD6 = 3'd6;
  localparam action_t ACT_RSVD7 = 3'd7;

  localparam int NumDirected   = 25;
  localparam int ItemsPerPhase = 338;
  localparam int StallLimit    = 2000;
  localparam int DrainCycles   = 8;

  typedef enum int {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  // one stimulus row; known marks a hand-typed expectation
  typedef struct packed {
    action_t action;
    status_t status;
    logic    known;
    ctrl_t   cw;
    state_t  st;
  } drive_row_t;

  typedef struct packed {
    ctrl_t  cw;
    state_t st;
  } drive_cmd_t;

  localparam drive_row_t DirectedRows [NumDirected] = '{
    '{ACT_NONE,    16'h0000, 1'b1, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'hFFFF, 1'b1, CW_NONE,     ST_NOTREADY},
    '{ACT_ENABLE,  16'h0040, 1'b1, CW_SHUTDOWN, ST_SOD},
    '{ACT_NONE,    16'hFFA1, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h0023, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h8027, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_QSTOP,   16'h0027, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h0007, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_ENABLE,  16'h0007, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_ENABLE,  16'h0000, 1'b1, CW_NONE,     ST_NOTREADY},
    '{ACT_QSTOP,   16'h0040, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_DISABLE, 16'h0027, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_FRESET,  16'h0008, 1'b1, CW_FRESET,   ST_FAULT},
    '{ACT_NONE,    16'h7FB8, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_FRESET,  16'h000F, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h0008, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_FRESET,  16'h0008, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_FRESET,  16'h0008, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h0021, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_RSVD5,   16'hFFFF, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_RSVD6,   16'h0008, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_RSVD7,   16'h0040, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_FRESET,  16'h0040, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_NONE,    16'h0008, 1'b0, CW_NONE,     ST_NOTREADY},
    '{ACT_ENABLE,  16'h002F, 1'b0, CW_NONE,     ST_NOTREADY}
  };

  logic clk = 1'b0;
  logic rst_n;

  dssq_in_if  in_ch ();
  dssq_out_if out_ch ();

  drive_state_controlword_sequencer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // mirror of the sequencer's target and fault-reset flags
  goal_t model_goal       = GOAL_NONE;
  logic  model_fr_pending = 1'b0;
  logic  model_fr_sent    = 1'b0;

  drive_cmd_t expected_commands [$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // apply request, decode status word, pick the control word
  function automatic void predict_command(input action_t act, input status_t sw,
                                          output ctrl_t cw, output state_t st);
    case (act)
      ACT_ENABLE:  model_goal = GOAL_ENABLE;
      ACT_DISABLE: model_goal = GOAL_DISABLE;
      ACT_QSTOP:   model_goal = GOAL_QSTOP;
      ACT_FRESET: begin
        model_fr_pending = 1'b1;
        model_fr_sent    = 1'b0;
      end
      default: ;
    endcase

    // walk down so the lowest matching entry wins
    st = ST_NOTREADY;
    for (int i = NumStates - 1; i >= 0; i--) begin
      if ((sw & MATCH_MASK[i]) == MATCH_VALUE[i]) st = state_t'(i);
    end

    if (st != ST_FAULT) begin
      model_fr_pending = 1'b0;
      model_fr_sent    = 1'b0;
    end

    cw = CW_NONE;
    if (st == ST_FAULT || st == ST_REACTION) begin
      if (model_fr_pending && !model_fr_sent) begin
        model_fr_sent = 1'b1;
        cw = CW_FRESET;
      end
    end else begin
      case (model_goal)
        GOAL_QSTOP: begin
          if (st inside {ST_READY, ST_ON, ST_ENABLED, ST_QSTOP}) cw = CW_QSTOP;
        end
        GOAL_ENABLE: begin
          case (st)
            ST_SOD:             cw = CW_SHUTDOWN;
            ST_READY:           cw = CW_SWITCHON;
            ST_ON, ST_ENABLED:  cw = CW_ENABLEOP;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  endfunction

  // present one transaction, wait for the handshake, record what should come back
  task automatic send_request(input drive_row_t row);
    ctrl_t      cw;
    state_t     st;
    drive_cmd_t exp_cmd;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= row.action;
    in_ch.status_word <= row.status;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_command(row.action, row.status, cw, st);
    if (row.known) begin
      exp_cmd.cw = row.cw;
      exp_cmd.st = row.st;
    end else begin
      exp_cmd.cw = cw;
      exp_cmd.st = st;
    end
    expected_commands.push_back(exp_cmd);
  endtask

  // receiver back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_commands.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction cw=0x%0h state=%0d",
                                  out_ch.control_word, out_ch.drive_state));
      end else begin
        exp_cmd = expected_commands.pop_front();
        if (out_ch.control_word !== exp_cmd.cw)
          report_mismatch($sformatf("control_word got 0x%0h expected 0x%0h",
                                    out_ch.control_word, exp_cmd.cw));
        if (out_ch.drive_state !== exp_cmd.st)
          report_mismatch($sformatf("drive_state got %0d expected %0d",
                                    out_ch.drive_state, exp_cmd.st));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    drive_row_t row;
    state_t     drive_sim;
    int         hold_left;
    int         pick;
    drive_sim = ST_NOTREADY;
    hold_left = 0;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_NONE;
    in_ch.status_word <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NumDirected; i++) send_request(DirectedRows[i]);

    // random drive walk under each idling mix
    for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
      case (idle_phase_e'(ph))
        PH_STEADY:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PH_SEND_IDLE:  begin send_idle_pct = 58; recv_stall_pct = 0;  end
        PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default:       begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // the simulated drive sits in one state for one to six requests
        if (hold_left == 0) begin
          if ($urandom_range(0, 99) < 20) drive_sim = ST_FAULT;
          else drive_sim = state_t'($urandom_range(0, NumStates - 1));
          hold_left = $urandom_range(1, 6);
        end
        hold_left--;
        row.known = 1'b0;
        row.cw    = CW_NONE;
        row.st    = ST_NOTREADY;
        if ($urandom_range(0, 99) < 12)
          row.status = status_t'($urandom);
        else
          row.status = (status_t'($urandom) & ~MATCH_MASK[drive_sim]) | MATCH_VALUE[drive_sim];
        pick = $urandom_range(0, 99);
        if (pick < 50)      row.action = ACT_NONE;
        else if (pick < 64) row.action = ACT_FRESET;
        else                row.action = action_t'($urandom_range(1, 7));
        send_request(row);
      end
      // hold off until the pipeline has drained
      in_ch.valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clk);
    end

    in_ch.valid <= 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
